### rtl/homography_circle_residual_top_defines.svh
// Assertion macros used by homography_circle_residual_top.sv.
`ifndef HOMOGRAPHY_CIRCLE_RESIDUAL_TOP_DEFINES_SVH
`define HOMOGRAPHY_CIRCLE_RESIDUAL_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Property holds at every edge outside reset.
`define HCR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define HCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define HCR_ASSERT(lbl, clk, rstn, prop, msg)
`define HCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/hcr_pkg.sv
package hcr_pkg;

    localparam logic [30:0] SAT_MAG = 31'h7FFF_FFFF;
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

    // Register indexes
    localparam logic [2:0] REG_COEF_ROW0 = 3'd0;
    localparam logic [2:0] REG_COEF_ROW0B = 3'd1;
    localparam logic [2:0] REG_COEF_ROW1 = 3'd2;
    localparam logic [2:0] REG_COEF_ROW2 = 3'd3;
    localparam logic [2:0] REG_ROI = 3'd4;
    localparam logic [2:0] REG_RADIUS = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // Micro-ops of the shared multiplier
    typedef enum logic [3:0] {
        OP_U0, OP_U1, OP_V0, OP_V1, OP_W0, OP_W1, OP_X2, OP_Y2, OP_RR, OP_RES2
    } op_t;

endpackage

### rtl/homography_circle_residual_top.sv
// Point-to-circle residual through an inverse homography, Q16.16 fixed point.
// One contour point at a time: s_tready is high only while the block is idle.
// A point runs u, v, w on the one shared 33x33 multiplier, then the two
// divisions by w in the bit-serial divider (cut short when the quotient
// saturates), then the squares, then the load of the output register and
// the return to idle. The point marked last adds the bit-serial square root;
// a zero w skips the divisions and every square but that of the residual.
// The result sits in an output register, so the next point is accepted
// while it waits.
`include "homography_circle_residual_top_defines.svh"
module homography_circle_residual_top #(
    parameter int COORD_BITS = 12,
    localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [2:0]      cfg_wr_index,
    input  logic [63:0]     cfg_wr_data,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,   // point_x, point_y
    input  logic            s_tlast,   // last_point
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,   // residual, total_norm
    output logic            m_tlast,   // is_last
    output logic [0:0]      m_tuser    // divide_fault
);
    import hcr_pkg::*;

    localparam int PXW   = COORD_BITS + 1;
    localparam int ACC_W = 32 + PXW + 3;
    localparam int MAG_W = ACC_W - 1;
    localparam int RW    = (2 * COORD_BITS > 24) ? 2 * COORD_BITS : 24;

    // Configuration registers
    logic [63:0] coef0_reg, coef1_reg, coef2_reg, coef3_reg;
    logic [23:0] roi_reg;
    logic [31:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef0_reg  <= '0;
            coef1_reg  <= '0;
            coef2_reg  <= '0;
            coef3_reg  <= '0;
            roi_reg    <= '0;
            radius_reg <= 32'h0001_0000;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_COEF_ROW0:  coef0_reg  <= cfg_wr_data;
                REG_COEF_ROW0B: coef1_reg  <= cfg_wr_data;
                REG_COEF_ROW1:  coef2_reg  <= cfg_wr_data;
                REG_COEF_ROW2:  coef3_reg  <= cfg_wr_data;
                REG_ROI:        roi_reg    <= cfg_wr_data[23:0];
                REG_RADIUS:     radius_reg <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    logic [RW-1:0] roi_ext;
    assign roi_ext = RW'(roi_reg);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [PXW-1:0] px_reg, px_next, py_reg, py_next;
    logic last_reg, last_next, fault_reg, fault_next, sel_reg, sel_next;
    logic signed [ACC_W-1:0] u_reg, u_next, v_reg, v_next, w_reg, w_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [30:0] xm_reg, xm_next, ym_reg, ym_next;
    logic [63:0] sq_reg, sq_next, sum_reg, sum_next;
    logic signed [31:0] res_reg, res_next;
    logic [31:0] norm_reg, norm_next;
    logic ov_reg, ov_next;
    logic [63:0] od_reg, od_next;
    logic ol_reg, ol_next, of_reg, of_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] prod_acc;
    logic [31:0] res_mag;
    logic div_start, sqrt_start, div_done, sqrt_done;
    logic [MAG_W-1:0] div_num, div_den;
    logic [30:0] div_q;
    logic [31:0] root;
    logic signed [48:0] diff;
    logic [64:0] sum_add;
    logic signed [ACC_W-1:0] w_acc;
    logic [MAG_W-1:0] u_mag, v_mag, w_mag;

    function automatic logic signed [32:0] cx(input logic [31:0] c);
        return {c[31], c};
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = (a < 0) ? -a : a;
        return t[MAG_W-1:0];
    endfunction

    // Shared multiplier operand select
    always_comb begin
        unique case (op_reg)
            OP_U0: begin mul_a = cx(coef0_reg[63:32]); mul_b = 33'(px_reg); end
            OP_U1: begin mul_a = cx(coef0_reg[31:0]);  mul_b = 33'(py_reg); end
            OP_V0: begin mul_a = cx(coef1_reg[31:0]);  mul_b = 33'(px_reg); end
            OP_V1: begin mul_a = cx(coef2_reg[63:32]); mul_b = 33'(py_reg); end
            OP_W0: begin mul_a = cx(coef3_reg[63:32]); mul_b = 33'(px_reg); end
            OP_W1: begin mul_a = cx(coef3_reg[31:0]);  mul_b = 33'(py_reg); end
            OP_X2: begin mul_a = 33'(xm_reg); mul_b = 33'(xm_reg); end
            OP_Y2: begin mul_a = 33'(ym_reg); mul_b = 33'(ym_reg); end
            OP_RR: begin mul_a = 33'(radius_reg); mul_b = 33'(radius_reg); end
            default: begin mul_a = 33'(res_mag); mul_b = 33'(res_mag); end
        endcase
    end

    assign res_mag  = (res_reg < 0) ? 32'(-res_reg) : 32'(res_reg);
    assign prod_acc = $signed(prod_reg[ACC_W-1:0]);
    assign w_acc    = w_reg + prod_acc;
    assign u_mag    = mag(u_reg);
    assign v_mag    = mag(v_reg);
    assign w_mag    = mag(w_reg);
    assign diff     = $signed({1'b0, sq_reg[63:16]}) - $signed({1'b0, prod_reg[63:16]});
    assign sum_add  = {1'b0, sum_reg} + {1'b0, prod_reg[63:0]};

    // Sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        last_next  = last_reg;
        fault_next = fault_reg;
        sel_next   = sel_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        prod_next  = prod_reg;
        xm_next    = xm_reg;
        ym_next    = ym_reg;
        sq_next    = sq_reg;
        sum_next   = sum_reg;
        res_next   = res_reg;
        norm_next  = norm_reg;
        ov_next    = ov_reg & ~m_tready;
        od_next    = od_reg;
        ol_next    = ol_reg;
        of_next    = of_reg;
        div_start  = 1'b0;
        div_num    = u_mag;
        div_den    = mag(w_acc);
        sqrt_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    px_next    = PXW'(s_tdata[COORD_BITS-1:0])
                               + PXW'(roi_ext[2*COORD_BITS-1:COORD_BITS]);
                    py_next    = PXW'(s_tdata[2*COORD_BITS-1:COORD_BITS])
                               + PXW'(roi_ext[COORD_BITS-1:0]);
                    last_next  = s_tlast;
                    fault_next = 1'b0;
                    norm_next  = '0;
                    u_next     = ACC_W'($signed(coef1_reg[63:32]));
                    v_next     = ACC_W'($signed(coef2_reg[31:0]));
                    w_next     = ACC_W'($signed(ONE_Q24));
                    op_next    = OP_U0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = 66'(mul_a * mul_b);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_MUL;
                unique case (op_reg)
                    OP_U0: begin u_next = u_reg + prod_acc; op_next = OP_U1; end
                    OP_U1: begin u_next = u_reg + prod_acc; op_next = OP_V0; end
                    OP_V0: begin v_next = v_reg + prod_acc; op_next = OP_V1; end
                    OP_V1: begin v_next = v_reg + prod_acc; op_next = OP_W0; end
                    OP_W0: begin w_next = w_acc; op_next = OP_W1; end
                    OP_W1: begin
                        w_next = w_acc;
                        if (w_acc == '0) begin
                            fault_next = 1'b1;
                            res_next   = $signed({1'b0, SAT_MAG});
                            op_next    = OP_RES2;
                        end else begin
                            div_start  = 1'b1;
                            sel_next   = 1'b0;
                            state_next = ST_DIV;
                        end
                    end
                    OP_X2: begin sq_next = prod_reg[63:0]; op_next = OP_Y2; end
                    OP_Y2: begin sq_next = sq_reg + prod_reg[63:0]; op_next = OP_RR; end
                    OP_RR: begin
                        if (diff > 49'sh0_7FFF_FFFF)
                            res_next = $signed({1'b0, SAT_MAG});
                        else if (diff < -49'sh0_8000_0000)
                            res_next = $signed({1'b1, 31'b0});
                        else
                            res_next = diff[31:0];
                        op_next = OP_RES2;
                    end
                    default: begin
                        sum_next = sum_add[64] ? '1 : sum_add[63:0];
                        if (last_reg) begin
                            sqrt_start = 1'b1;
                            state_next = ST_SQRT;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                div_num = v_mag;
                div_den = w_mag;
                if (div_done) begin
                    if (!sel_reg) begin
                        xm_next   = div_q;
                        sel_next  = 1'b1;
                        div_start = 1'b1;
                    end else begin
                        ym_next    = div_q;
                        op_next    = OP_X2;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    norm_next  = root;
                    sum_next   = '0;
                    state_next = ST_OUT;
                end
            end
            default: begin
                if (!ov_reg || m_tready) begin
                    ov_next    = 1'b1;
                    od_next    = {norm_reg, res_reg};
                    ol_next    = last_reg;
                    of_next    = fault_reg;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            ov_reg    <= ov_next;
        end
        op_reg    <= op_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        last_reg  <= last_next;
        fault_reg <= fault_next;
        sel_reg   <= sel_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        prod_reg  <= prod_next;
        xm_reg    <= xm_next;
        ym_reg    <= ym_next;
        sq_reg    <= sq_next;
        res_reg   <= res_next;
        norm_reg  <= norm_next;
        od_reg    <= od_next;
        ol_reg    <= ol_next;
        of_reg    <= of_next;
    end

    hcr_div #(.NW(MAG_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    hcr_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sum_next),
        .done     (sqrt_done),
        .root     (root)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = ov_reg;
    assign m_tdata    = od_reg;
    assign m_tlast    = ol_reg;
    assign m_tuser[0] = of_reg;

    `HCR_ASSERT(a_fault_sat, aclk, aresetn, !(m_tvalid && m_tuser[0]) || (m_tdata[31:0] == 32'h7FFF_FFFF), "fault without saturated residual")
    `HCR_ASSERT(a_norm_zero, aclk, aresetn, !(m_tvalid && !m_tlast) || (m_tdata[63:32] == 32'd0), "norm set on a beat that is not last")
    `HCR_ASSERT_NEXT(a_accept_mul, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_MUL, "accepted point did not start the multiplier")
endmodule

### rtl/hcr_div.sv
module hcr_div #(
    parameter int NW = 47
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic          done,
    output logic [30:0]   quot
);
    import hcr_pkg::*;

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] den_reg, den_next;
    logic [30:0]   nsh_reg, nsh_next;
    logic [30:0]   q_reg, q_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [NW:0]   rem_t;
    logic          ge;
    logic [NW-1:0] num_hi;

    assign num_hi = num >> 15;
    assign rem_t  = {rem_reg, nsh_reg[30]};
    assign ge     = rem_t >= {1'b0, den_reg};

    // Restoring division, one quotient bit per cycle; a quotient that would not fit saturates to SAT_MAG
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        nsh_next  = nsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            den_next = den;
            if (num_hi >= den) begin
                q_next    = SAT_MAG;
                done_next = 1'b1;
            end else begin
                rem_next = num_hi;
                nsh_next = {num[14:0], 16'b0};
                q_next   = '0;
                cnt_next = 5'd30;
                run_next = 1'b1;
            end
        end else if (run_reg) begin
            rem_next = ge ? NW'(rem_t - {1'b0, den_reg}) : NW'(rem_t);
            q_next   = {q_reg[29:0], ge};
            nsh_next = {nsh_reg[29:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        nsh_reg <= nsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

### rtl/hcr_sqrt.sv
module hcr_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    // Digit-by-digit root, one result bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = radicand;
            res_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule
